[rtl/fpr_pkg.sv]
// Shared types, codes and the byte-wide CRC-16/XMODEM step for the framed
// packet receiver. No dependencies.
`default_nettype none

package fpr_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned BCNT_W     = 17;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PATTERN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERSION  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 2'd2;

	localparam logic [15:0] HEAD_PATTERN_RST = 16'hFA55;
	localparam logic [7:0]  MAX_VERSION_RST  = 8'd1;
	localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1024;

	// status codes
	localparam logic [2:0] ST_HUNT = 3'd0;
	localparam logic [2:0] ST_RECV = 3'd1;
	localparam logic [2:0] ST_DONE = 3'd2;
	localparam logic [2:0] ST_BUSY = 3'd3;
	localparam logic [2:0] ST_VERR = 3'd4;
	localparam logic [2:0] ST_SERR = 3'd5;
	localparam logic [2:0] ST_CERR = 3'd6;

	// phase codes
	localparam logic [3:0] PH_HEADER  = 4'd0;
	localparam logic [3:0] PH_VERSION = 4'd1;
	localparam logic [3:0] PH_TYPE    = 4'd2;
	localparam logic [3:0] PH_ADDRESS = 4'd3;
	localparam logic [3:0] PH_COMMAND = 4'd4;
	localparam logic [3:0] PH_SUBCMD  = 4'd5;
	localparam logic [3:0] PH_LENGTH  = 4'd6;
	localparam logic [3:0] PH_PAYLOAD = 4'd7;
	localparam logic [3:0] PH_RESULT  = 4'd8;
	localparam logic [3:0] PH_CRC     = 4'd9;

	// header, five fixed fields and two length bytes
	localparam logic [BCNT_W-1:0] HDR_FIXED_LEN = 17'd9;
	localparam logic [BCNT_W-1:0] CRC_TAIL_LEN  = 17'd3;
	localparam logic [15:0]       CRC_POLY      = 16'h1021;

	typedef struct packed {
		logic [2:0]        status;
		logic [3:0]        phase;
		logic [BCNT_W-1:0] byte_index;
		logic              byte_stored;
		logic [7:0]        stored_byte;
		logic [7:0]        version;
		logic [7:0]        frame_type;
		logic [7:0]        address;
		logic [7:0]        command;
		logic [7:0]        subcommand;
		logic [15:0]       payload_length;
		logic [7:0]        result_code;
	} result_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/fpr_obuf.sv]
// Two-entry result buffer (output register plus skid stage).
// Uses fpr_pkg::result_t.
`default_nettype none

module fpr_obuf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire fpr_pkg::result_t push_data,
	output logic                 can_push,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output fpr_pkg::result_t     out_data
);

	logic             out_valid_q;
	logic             skid_valid_q;
	fpr_pkg::result_t out_q;
	fpr_pkg::result_t skid_q;
	logic             pop;

	assign pop       = out_valid_q && out_ready;
	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/framed_packet_receiver_crc16_core.sv]
// Each accepted item's result is registered in fpr_obuf, in its output register or in its skid stage.
// Throughput: one item per cycle; the header hunt, field capture and byte-wide
// CRC step are combinational, and in_ready drops only while two results wait.
// Reset clears all frame state and loads the configuration registers with
// their defaults; no clearing pass.
// Top level of the framed packet receiver; uses fpr_pkg and fpr_obuf.
`default_nettype none

module framed_packet_receiver_crc16_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             mode,
	input  wire logic [7:0]                       data_byte,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [2:0]                            status,
	output logic [3:0]                            phase,
	output logic [fpr_pkg::BCNT_W-1:0]            byte_index,
	output logic                                  byte_stored,
	output logic [7:0]                            stored_byte,
	output logic [7:0]                            version,
	output logic [7:0]                            frame_type,
	output logic [7:0]                            address,
	output logic [7:0]                            command,
	output logic [7:0]                            subcommand,
	output logic [15:0]                           payload_length,
	output logic [7:0]                            result_code,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [fpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fpr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [15:0] head_q;
	logic [7:0]  maxver_q;
	logic [15:0] maxpay_q;

	logic [3:0]                   phase_q, phase_d;
	logic                         frame_done_q, frame_done_d;
	logic [15:0]                  hdr_q, hdr_d;
	logic [fpr_pkg::BCNT_W-1:0]   bcnt_q, bcnt_d;
	logic [15:0]                  crc_q, crc_d;
	logic [15:0]                  rcrc_q, rcrc_d;
	logic [15:0]                  len_q, len_d;
	logic [7:0]                   ver_q, ver_d;
	logic [7:0]                   typ_q, typ_d;
	logic [7:0]                   addr_q, addr_d;
	logic [7:0]                   cmd_q, cmd_d;
	logic [7:0]                   sub_q, sub_d;
	logic [7:0]                   res_q, res_d;

	logic                         in_acc;
	logic                         can_push;
	logic [fpr_pkg::BCNT_W-1:0]   bc_inc;
	logic [fpr_pkg::BCNT_W-1:0]   len_end;
	logic [fpr_pkg::BCNT_W-1:0]   crc_end;
	logic [15:0]                  crc_upd;
	logic [15:0]                  len_v;
	logic [15:0]                  rcrc_v;
	logic                         err;
	logic [2:0]                   err_code;
	fpr_pkg::result_t             res;
	fpr_pkg::result_t             out_data;

	assign in_ready  = can_push;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign bc_inc  = bcnt_q + 17'd1;
	assign len_end = {1'b0, len_q} + fpr_pkg::HDR_FIXED_LEN;
	assign crc_end = len_end + fpr_pkg::CRC_TAIL_LEN;
	assign crc_upd = fpr_pkg::crc16_byte(crc_q, data_byte);
	assign len_v   = {len_q[7:0], data_byte};
	assign rcrc_v  = {rcrc_q[7:0], data_byte};

	always_comb begin
		phase_d      = phase_q;
		frame_done_d = frame_done_q;
		hdr_d        = hdr_q;
		bcnt_d       = bcnt_q;
		crc_d        = crc_q;
		rcrc_d       = rcrc_q;
		len_d        = len_q;
		ver_d        = ver_q;
		typ_d        = typ_q;
		addr_d       = addr_q;
		cmd_d        = cmd_q;
		sub_d        = sub_q;
		res_d        = res_q;
		err          = 1'b0;
		err_code     = fpr_pkg::ST_HUNT;
		res          = '0;

		if (mode) begin
			err = 1'b1;
			err_code = fpr_pkg::ST_HUNT;
		end else if (frame_done_q) begin
			res.status = fpr_pkg::ST_BUSY;
			res.phase  = fpr_pkg::PH_CRC;
		end else begin
			if (phase_q >= fpr_pkg::PH_VERSION && phase_q <= fpr_pkg::PH_RESULT) begin
				crc_d = crc_upd;
			end
			if (phase_q >= fpr_pkg::PH_VERSION && phase_q <= fpr_pkg::PH_CRC) begin
				res.byte_index  = bcnt_q;
				res.byte_stored = 1'b1;
				res.stored_byte = data_byte;
				bcnt_d          = bc_inc;
			end
			unique case (phase_q)
				fpr_pkg::PH_HEADER: begin
					hdr_d = {hdr_q[7:0], data_byte};
					if ({hdr_q[7:0], data_byte} == head_q) begin
						res.byte_index  = 17'd1;
						res.byte_stored = 1'b1;
						res.stored_byte = data_byte;
						bcnt_d          = 17'd2;
						crc_d           = '0;
						phase_d         = fpr_pkg::PH_VERSION;
					end
				end
				fpr_pkg::PH_VERSION: begin
					if (data_byte <= maxver_q) begin
						ver_d   = data_byte;
						phase_d = fpr_pkg::PH_TYPE;
					end else begin
						err      = 1'b1;
						err_code = fpr_pkg::ST_VERR;
					end
				end
				fpr_pkg::PH_TYPE: begin
					typ_d   = data_byte;
					phase_d = fpr_pkg::PH_ADDRESS;
				end
				fpr_pkg::PH_ADDRESS: begin
					addr_d  = data_byte;
					phase_d = fpr_pkg::PH_COMMAND;
				end
				fpr_pkg::PH_COMMAND: begin
					cmd_d   = data_byte;
					phase_d = fpr_pkg::PH_SUBCMD;
				end
				fpr_pkg::PH_SUBCMD: begin
					sub_d   = data_byte;
					phase_d = fpr_pkg::PH_LENGTH;
				end
				fpr_pkg::PH_LENGTH: begin
					if (bc_inc >= fpr_pkg::HDR_FIXED_LEN) begin
						if (len_v > maxpay_q) begin
							err      = 1'b1;
							err_code = fpr_pkg::ST_SERR;
						end else begin
							len_d   = len_v;
							phase_d = (len_v == 16'd0) ? fpr_pkg::PH_RESULT
								: fpr_pkg::PH_PAYLOAD;
						end
					end else begin
						len_d = len_v;
					end
				end
				fpr_pkg::PH_PAYLOAD: begin
					if (bc_inc >= len_end) begin
						phase_d = fpr_pkg::PH_RESULT;
					end
				end
				fpr_pkg::PH_RESULT: begin
					res_d   = data_byte;
					phase_d = fpr_pkg::PH_CRC;
				end
				fpr_pkg::PH_CRC: begin
					if (bc_inc >= crc_end) begin
						if (rcrc_v == crc_q) begin
							rcrc_d       = rcrc_v;
							frame_done_d = 1'b1;
						end else begin
							err      = 1'b1;
							err_code = fpr_pkg::ST_CERR;
						end
					end else begin
						rcrc_d = rcrc_v;
					end
				end
				default: begin
				end
			endcase

			if (!err) begin
				if (frame_done_d) begin
					res.status = fpr_pkg::ST_DONE;
					res.phase  = fpr_pkg::PH_CRC;
				end else begin
					res.status = (phase_d == fpr_pkg::PH_HEADER) ? fpr_pkg::ST_HUNT
						: fpr_pkg::ST_RECV;
					res.phase  = phase_d;
				end
			end
		end

		// error or release: drop the frame and hunt again
		if (err) begin
			phase_d      = fpr_pkg::PH_HEADER;
			frame_done_d = 1'b0;
			hdr_d        = '0;
			bcnt_d       = '0;
			crc_d        = '0;
			rcrc_d       = '0;
			res_d        = '0;
			res.status   = err_code;
			res.phase    = fpr_pkg::PH_HEADER;
		end

		res.version        = ver_d;
		res.frame_type     = typ_d;
		res.address        = addr_d;
		res.command        = cmd_d;
		res.subcommand     = sub_d;
		res.payload_length = len_d;
		res.result_code    = res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= fpr_pkg::PH_HEADER;
			frame_done_q <= 1'b0;
			hdr_q        <= '0;
			bcnt_q       <= '0;
			crc_q        <= '0;
			rcrc_q       <= '0;
			len_q        <= '0;
			ver_q        <= '0;
			typ_q        <= '0;
			addr_q       <= '0;
			cmd_q        <= '0;
			sub_q        <= '0;
			res_q        <= '0;
		end else if (in_acc) begin
			phase_q      <= phase_d;
			frame_done_q <= frame_done_d;
			hdr_q        <= hdr_d;
			bcnt_q       <= bcnt_d;
			crc_q        <= crc_d;
			rcrc_q       <= rcrc_d;
			len_q        <= len_d;
			ver_q        <= ver_d;
			typ_q        <= typ_d;
			addr_q       <= addr_d;
			cmd_q        <= cmd_d;
			sub_q        <= sub_d;
			res_q        <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= fpr_pkg::HEAD_PATTERN_RST;
			maxver_q <= fpr_pkg::MAX_VERSION_RST;
			maxpay_q <= fpr_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fpr_pkg::CFG_HEAD_PATTERN: head_q   <= cfg_data;
				fpr_pkg::CFG_MAX_VERSION:  maxver_q <= cfg_data[7:0];
				fpr_pkg::CFG_MAX_PAYLOAD:  maxpay_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fpr_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.push_data (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign status         = out_data.status;
	assign phase          = out_data.phase;
	assign byte_index     = out_data.byte_index;
	assign byte_stored    = out_data.byte_stored;
	assign stored_byte    = out_data.stored_byte;
	assign version        = out_data.version;
	assign frame_type     = out_data.frame_type;
	assign address        = out_data.address;
	assign command        = out_data.command;
	assign subcommand     = out_data.subcommand;
	assign payload_length = out_data.payload_length;
	assign result_code    = out_data.result_code;

	a_done_in_crc: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done_q |-> phase_q == fpr_pkg::PH_CRC)
		else $error("held frame outside crc phase");

	a_hunt_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == fpr_pkg::PH_HEADER |-> bcnt_q == '0)
		else $error("byte count running while hunting");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && mode |=> phase_q == fpr_pkg::PH_HEADER && !frame_done_q)
		else $error("release did not restart hunting");

	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for framed_packet_receiver_crc16_core: byte-level
// predictor, directed frames, then random framed traffic under several settings.
// Depends on fpr_pkg and the core RTL only.
`default_nettype none

module tb_top;

	typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_VER, FR_BAD_LEN, FR_CUT} frame_kind_t;
	typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_WAVE} rx_style_t;
	typedef logic [fpr_pkg::CFG_IDX_W-1:0] cfg_idx_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           mode = 1'b0;
	logic [7:0]                     data_byte = 8'h00;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [2:0]                     status;
	logic [3:0]                     phase;
	logic [fpr_pkg::BCNT_W-1:0]     byte_index;
	logic                           byte_stored;
	logic [7:0]                     stored_byte;
	logic [7:0]                     version;
	logic [7:0]                     frame_type;
	logic [7:0]                     address;
	logic [7:0]                     command;
	logic [7:0]                     subcommand;
	logic [15:0]                    payload_length;
	logic [7:0]                     result_code;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	cfg_idx_t                       cfg_index = fpr_pkg::CFG_HEAD_PATTERN;
	logic [fpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	framed_packet_receiver_crc16_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .phase(phase), .byte_index(byte_index), .byte_stored(byte_stored),
		.stored_byte(stored_byte), .version(version), .frame_type(frame_type),
		.address(address), .command(command), .subcommand(subcommand),
		.payload_length(payload_length), .result_code(result_code),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor copy of the configuration and frame state
	logic [15:0]                cfg_head = fpr_pkg::HEAD_PATTERN_RST;
	logic [7:0]                 cfg_maxver = fpr_pkg::MAX_VERSION_RST;
	logic [15:0]                cfg_maxlen = fpr_pkg::MAX_PAYLOAD_RST;
	logic [3:0]                 rx_phase = fpr_pkg::PH_HEADER;
	logic                       rx_held = 1'b0;
	logic [15:0]                hdr_sr = '0;
	logic [fpr_pkg::BCNT_W-1:0] pos_count = '0;
	logic [15:0]                crc_acc = '0;
	logic [15:0]                crc_rx = '0;
	logic [15:0]                len_q = '0;
	logic [7:0]        ver_q = '0, typ_q = '0, addr_q = '0, cmd_q = '0, sub_q = '0, res_q = '0;

	fpr_pkg::result_t frame_results_q[$];
	int        mismatches = 0;
	int        results_checked = 0;
	int        items_sent = 0;
	int        reg_writes = 0;
	int        status_seen[8] = '{default: 0};
	int        burst_left = 0;
	logic [15:0] tx_crc = '0;
	rx_style_t rx_style = RX_FREE;
	int        rx_left = 0;

	function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) c = c ^ fpr_pkg::CRC_POLY;
		end
		return c;
	endfunction

	function automatic void drop_frame();
		rx_phase = fpr_pkg::PH_HEADER;
		rx_held = 1'b0;
		hdr_sr = '0;
		pos_count = '0;
		crc_acc = '0;
		crc_rx = '0;
		res_q = '0;
	endfunction

	function automatic fpr_pkg::result_t model_byte(input logic m, input logic [7:0] b);
		fpr_pkg::result_t r;
		logic [15:0] crc;
		logic [15:0] v;
		logic        err_hit;
		logic [2:0]  err_code;
		r = '0;
		err_hit = 1'b0;
		err_code = fpr_pkg::ST_HUNT;
		if (m) begin
			drop_frame();
			r.status = fpr_pkg::ST_HUNT;
			r.phase = fpr_pkg::PH_HEADER;
		end else if (rx_held) begin
			r.status = fpr_pkg::ST_BUSY;
			r.phase = fpr_pkg::PH_CRC;
		end else begin
			crc = crc_acc;
			if (rx_phase >= fpr_pkg::PH_VERSION && rx_phase <= fpr_pkg::PH_RESULT)
				crc = crc_step(crc, b);
			if (rx_phase >= fpr_pkg::PH_VERSION && rx_phase <= fpr_pkg::PH_CRC) begin
				r.byte_index = pos_count;
				r.byte_stored = 1'b1;
				r.stored_byte = b;
				pos_count = pos_count + 1'b1;
			end
			case (rx_phase)
				fpr_pkg::PH_HEADER: begin
					hdr_sr = {hdr_sr[7:0], b};
					if (hdr_sr == cfg_head) begin
						r.byte_index = 17'd1;
						r.byte_stored = 1'b1;
						r.stored_byte = b;
						pos_count = 17'd2;
						crc = '0;
						rx_phase = fpr_pkg::PH_VERSION;
					end
				end
				fpr_pkg::PH_VERSION: begin
					if (b <= cfg_maxver) begin
						ver_q = b;
						rx_phase = fpr_pkg::PH_TYPE;
					end else begin
						err_hit = 1'b1;
						err_code = fpr_pkg::ST_VERR;
					end
				end
				fpr_pkg::PH_TYPE: begin
					typ_q = b;
					rx_phase = fpr_pkg::PH_ADDRESS;
				end
				fpr_pkg::PH_ADDRESS: begin
					addr_q = b;
					rx_phase = fpr_pkg::PH_COMMAND;
				end
				fpr_pkg::PH_COMMAND: begin
					cmd_q = b;
					rx_phase = fpr_pkg::PH_SUBCMD;
				end
				fpr_pkg::PH_SUBCMD: begin
					sub_q = b;
					rx_phase = fpr_pkg::PH_LENGTH;
				end
				fpr_pkg::PH_LENGTH: begin
					v = {len_q[7:0], b};
					if (pos_count >= fpr_pkg::HDR_FIXED_LEN) begin
						if (v > cfg_maxlen) begin
							err_hit = 1'b1;
							err_code = fpr_pkg::ST_SERR;
						end else begin
							len_q = v;
							rx_phase = (v == 16'd0) ? fpr_pkg::PH_RESULT
								: fpr_pkg::PH_PAYLOAD;
						end
					end else begin
						len_q = v;
					end
				end
				fpr_pkg::PH_PAYLOAD: begin
					if (pos_count >= fpr_pkg::HDR_FIXED_LEN + len_q)
						rx_phase = fpr_pkg::PH_RESULT;
				end
				fpr_pkg::PH_RESULT: begin
					res_q = b;
					rx_phase = fpr_pkg::PH_CRC;
				end
				fpr_pkg::PH_CRC: begin
					v = {crc_rx[7:0], b};
					if (pos_count >= fpr_pkg::HDR_FIXED_LEN + fpr_pkg::CRC_TAIL_LEN
							+ len_q) begin
						if (v == crc) begin
							crc_rx = v;
							rx_held = 1'b1;
						end else begin
							err_hit = 1'b1;
							err_code = fpr_pkg::ST_CERR;
						end
					end else begin
						crc_rx = v;
					end
				end
				default: ;
			endcase
			crc_acc = crc;
			if (err_hit) begin
				drop_frame();
				r.status = err_code;
				r.phase = fpr_pkg::PH_HEADER;
			end else if (rx_held) begin
				r.status = fpr_pkg::ST_DONE;
				r.phase = fpr_pkg::PH_CRC;
			end else begin
				r.status = (rx_phase == fpr_pkg::PH_HEADER) ? fpr_pkg::ST_HUNT
					: fpr_pkg::ST_RECV;
				r.phase = rx_phase;
			end
		end
		r.version = ver_q;
		r.frame_type = typ_q;
		r.address = addr_q;
		r.command = cmd_q;
		r.subcommand = sub_q;
		r.payload_length = len_q;
		r.result_code = res_q;
		return r;
	endfunction

	function automatic string fmt_result(input fpr_pkg::result_t r);
		return $sformatf({"st=%0d ph=%0d idx=%0d stored=%b byte=%h ver=%h typ=%h",
			" adr=%h cmd=%h sub=%h len=%h res=%h"},
			r.status, r.phase, r.byte_index, r.byte_stored, r.stored_byte, r.version,
			r.frame_type, r.address, r.command, r.subcommand, r.payload_length, r.result_code);
	endfunction

	// receiver stalls: a style held for a random stretch, then another
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 80);
		end
		rx_left--;
		case (rx_style)
			RX_FREE:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= ((rx_left % 6) < 3);
		endcase
	end

	always @(negedge clk) begin : check_results
		fpr_pkg::result_t got;
		fpr_pkg::result_t want;
		string   diffs;
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.phase = phase;
			got.byte_index = byte_index;
			got.byte_stored = byte_stored;
			got.stored_byte = stored_byte;
			got.version = version;
			got.frame_type = frame_type;
			got.address = address;
			got.command = command;
			got.subcommand = subcommand;
			got.payload_length = payload_length;
			got.result_code = result_code;
			results_checked++;
			if (frame_results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result with nothing expected: %s", fmt_result(got));
			end else begin
				want = frame_results_q.pop_front();
				diffs = "";
				if (got.status !== want.status) diffs = {diffs, " status"};
				if (got.phase !== want.phase) diffs = {diffs, " phase"};
				if (got.byte_index !== want.byte_index) diffs = {diffs, " byte_index"};
				if (got.byte_stored !== want.byte_stored) diffs = {diffs, " byte_stored"};
				if (got.stored_byte !== want.stored_byte) diffs = {diffs, " stored_byte"};
				if (got.version !== want.version) diffs = {diffs, " version"};
				if (got.frame_type !== want.frame_type) diffs = {diffs, " frame_type"};
				if (got.address !== want.address) diffs = {diffs, " address"};
				if (got.command !== want.command) diffs = {diffs, " command"};
				if (got.subcommand !== want.subcommand) diffs = {diffs, " subcommand"};
				if (got.payload_length !== want.payload_length) diffs = {diffs, " payload_length"};
				if (got.result_code !== want.result_code) diffs = {diffs, " result_code"};
				if (diffs != "") begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch in result %0d:%s", results_checked, diffs);
						$display("  expected %s", fmt_result(want));
						$display("  actual   %s", fmt_result(got));
					end
				end
			end
		end
	end

	// one item; the sender runs in bursts with idle gaps between them
	task automatic send_byte(input logic m, input logic [7:0] b);
		fpr_pkg::result_t r;
		int      gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= m;
		data_byte <= b;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		r = model_byte(m, b);
		frame_results_q.push_back(r);
		status_seen[r.status]++;
		if (r.status != fpr_pkg::ST_BUSY) items_sent++;
		@(posedge clk);
	endtask

	task automatic send_counted(input logic [7:0] b);
		tx_crc = crc_step(tx_crc, b);
		send_byte(1'b0, b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (frame_results_q.size() != 0) @(negedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apply_config(input logic [15:0] head, input logic [7:0] maxver,
			input logic [15:0] maxlen);
		logic [15:0] vals[3];
		vals[0] = head;
		vals[1] = {8'h00, maxver};
		vals[2] = maxlen;
		drain();
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			@(negedge clk);
			while (!cfg_ready) @(negedge clk);
			case (cfg_idx_t'(i))
				fpr_pkg::CFG_HEAD_PATTERN: cfg_head = vals[i];
				fpr_pkg::CFG_MAX_VERSION:  cfg_maxver = vals[i][7:0];
				fpr_pkg::CFG_MAX_PAYLOAD:  cfg_maxlen = vals[i];
				default: ;
			endcase
			reg_writes++;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_header();
		int tries;
		tries = 0;
		while (rx_phase == fpr_pkg::PH_HEADER && !rx_held && tries < 4) begin
			send_byte(1'b0, (tries % 2 == 0) ? cfg_head[15:8] : cfg_head[7:0]);
			tries++;
		end
	endtask

	task automatic send_frame(input frame_kind_t kind);
		logic [7:0]  fld[$];
		logic [15:0] crc;
		logic [15:0] len;
		logic [7:0]  ver;
		int          span;
		int          cut;
		if (rx_held || rx_phase != fpr_pkg::PH_HEADER) send_byte(1'b1, 8'($urandom));
		send_header();
		if (rx_phase != fpr_pkg::PH_VERSION) return;
		if (kind == FR_BAD_VER && cfg_maxver != 8'hFF)
			ver = 8'($urandom_range(int'(cfg_maxver) + 1, 255));
		else
			ver = 8'($urandom_range(0, int'(cfg_maxver)));
		if (kind == FR_BAD_LEN && cfg_maxlen != 16'hFFFF) begin
			len = $urandom_range(0, 1) ? cfg_maxlen + 16'd1
				: 16'($urandom_range(int'(cfg_maxlen) + 1, 65535));
		end else begin
			span = $urandom_range(0, 19);
			span = (span < 13) ? 6 : (span < 19) ? 24 : 200;
			len = 16'($urandom_range(0, span) % (int'(cfg_maxlen) + 1));
		end
		fld.push_back(ver);
		repeat (4) fld.push_back(8'($urandom));
		fld.push_back(len[15:8]);
		fld.push_back(len[7:0]);
		if (kind != FR_BAD_LEN) repeat (int'(len)) fld.push_back(8'($urandom));
		fld.push_back(8'($urandom));
		crc = '0;
		foreach (fld[i]) crc = crc_step(crc, fld[i]);
		if (kind == FR_BAD_CRC) crc = crc ^ (16'd1 << $urandom_range(0, 15));
		fld.push_back(crc[15:8]);
		fld.push_back(crc[7:0]);
		cut = (kind == FR_CUT) ? $urandom_range(1, fld.size() - 1) : fld.size();
		for (int i = 0; i < cut; i++) send_byte(1'b0, fld[i]);
	endtask

	task automatic run_traffic(input int n_items);
		int target;
		int pick;
		target = items_sent + n_items;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) send_frame(FR_GOOD);
			else if (pick < 70) send_frame(FR_BAD_CRC);
			else if (pick < 77) send_frame(FR_BAD_VER);
			else if (pick < 84) send_frame(FR_BAD_LEN);
			else if (pick < 92) send_frame(FR_CUT);
			else repeat ($urandom_range(1, 4))
				send_byte(($urandom_range(0, 9) == 0), 8'($urandom));
			if (rx_held || rx_phase != fpr_pkg::PH_HEADER) begin
				if (rx_held) repeat ($urandom_range(0, 2)) send_byte(1'b0, 8'($urandom));
				send_byte(1'b1, 8'($urandom));
			end
		end
	endtask

	task automatic test_release_idle();
		send_byte(1'b1, 8'hFF);
		send_byte(1'b0, 8'h00);
	endtask

	// zero-length frame with extreme field values
	task automatic test_good_frame();
		logic [15:0] c;
		tx_crc = '0;
		send_byte(1'b0, cfg_head[15:8]);
		send_byte(1'b0, cfg_head[7:0]);
		send_counted(8'h01);
		send_counted(8'hFF);
		send_counted(8'h00);
		send_counted(8'h80);
		send_counted(8'h7F);
		send_counted(8'h00);
		send_counted(8'h00);
		send_counted(8'hAA);
		c = tx_crc;
		send_byte(1'b0, c[15:8]);
		send_byte(1'b0, c[7:0]);
	endtask

	task automatic test_held_frame();
		send_byte(1'b0, 8'h5A);
		send_byte(1'b1, 8'h00);
	endtask

	task automatic test_version_error();
		send_byte(1'b0, cfg_head[15:8]);
		send_byte(1'b0, cfg_head[7:0]);
		send_byte(1'b0, cfg_maxver + 8'd1);
	endtask

	task automatic test_size_error();
		logic [15:0] len;
		len = cfg_maxlen + 16'd1;
		send_byte(1'b0, cfg_head[15:8]);
		send_byte(1'b0, cfg_head[7:0]);
		send_byte(1'b0, 8'h01);
		send_byte(1'b0, 8'h11);
		send_byte(1'b0, 8'h22);
		send_byte(1'b0, 8'h33);
		send_byte(1'b0, 8'h44);
		send_byte(1'b0, len[15:8]);
		send_byte(1'b0, len[7:0]);
	endtask

	task automatic test_crc_error();
		repeat (6) send_frame(FR_BAD_CRC);
	endtask

	task automatic test_traffic_default();
		run_traffic(200);
	endtask

	task automatic test_config_sweep();
		apply_config(16'h0000, 8'h00, 16'h0000);
		run_traffic(150);
		apply_config(16'hFFFF, 8'hFF, 16'hFFFF);
		run_traffic(150);
		apply_config(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 64)));
		run_traffic(150);
		apply_config(fpr_pkg::HEAD_PATTERN_RST, fpr_pkg::MAX_VERSION_RST,
			fpr_pkg::MAX_PAYLOAD_RST);
		run_traffic(60);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_release_idle();
		test_good_frame();
		test_held_frame();
		test_version_error();
		test_size_error();
		test_crc_error();
		test_traffic_default();
		test_config_sweep();
		drain();
		repeat (4) @(posedge clk);
		$display("sent %0d bytes and releases, %0d register writes, %0d results checked",
			items_sent, reg_writes, results_checked);
		$display("frames completed %0d, version/size/crc errors %0d/%0d/%0d, mismatches %0d",
			status_seen[fpr_pkg::ST_DONE], status_seen[fpr_pkg::ST_VERR],
			status_seen[fpr_pkg::ST_SERR], status_seen[fpr_pkg::ST_CERR], mismatches);
		if (mismatches == 0 && frame_results_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
